[sv/otm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// otm_pkg - shared types and constants for the overcurrent trip monitor
// Field widths, register reset values, register indexes, sequencer states
// and shared-unit operation codes.
// ----------------------------------------------------------------------------
package otm_pkg;

	localparam int ADC_W      = 12;   // raw converter reading
	localparam int SLOPE_W    = 16;   // scale slope, 2^-20 A per count
	localparam int OFFSET_W   = 16;   // signed offset, 1/1024 A
	localparam int SAMPLE_W   = 15;   // converted sample and mean, 1/1024 A
	localparam int FRAC_W     = 10;   // shift after the slope multiply
	localparam int PROD_W     = ADC_W + SLOPE_W - FRAC_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int OTM_WINDOW_LENGTH = 10;

	localparam logic [SLOPE_W-1:0]         SLOPE_RST   = 16'd8695;
	localparam logic signed [OFFSET_W-1:0] OFFSET_RST  = -16'sd2943;
	localparam logic [SAMPLE_W-1:0]        LEVEL_RST   = 15'd10240;
	localparam logic [SAMPLE_W-1:0]        MARGIN_RST  = 15'd512;
	localparam logic [SAMPLE_W-1:0]        SAMPLE_MAX  = 15'h7FFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCALE_SLOPE    = 2'd0,
		CFG_SCALE_OFFSET   = 2'd1,
		CFG_TRIP_LEVEL     = 2'd2,
		CFG_RELEASE_MARGIN = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_OFS,
		ST_SUB,
		ST_ADD,
		ST_DIV,
		ST_SET,
		ST_REL,
		ST_OUT
	} state_t;

endpackage
`default_nettype wire

[sv/otm_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// otm_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module otm_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 10,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[sv/otm_alu.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// otm_alu - shared signed add/subtract unit
// Serves offset add, level minus margin, total update, divider trial
// subtract and threshold compares; the result sign is the compare flag.
// ----------------------------------------------------------------------------
module otm_alu #(
	parameter int W = 21
) (
	input  wire otm_pkg::alu_op_t op,
	input  wire logic signed [W-1:0] a,
	input  wire logic signed [W-1:0] b,
	output logic signed [W-1:0] y,
	output logic                neg
);
	import otm_pkg::*;

	always_comb begin
		case (op)
			ALU_ADD: y = a + b;
			ALU_SUB: y = a - b;
			default: y = a - b;
		endcase
		neg = y[W-1];
	end

endmodule
`default_nettype wire

[sv/overcurrent_trip_monitor_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// overcurrent_trip_monitor_unit - moving average overcurrent trip monitor
// Scales each ADC sample to 1/1024 A, averages over the last WINDOW_LENGTH
// samples (fewer until the ring fills) and keeps a trip latch with hysteresis.
// ----------------------------------------------------------------------------
// Usage:
//   Input request: in_valid/in_ready with adc_sample. in_ready is high only
//   while the sequencer is idle; one sample is worked on at a time.
//   Output request: out_valid/out_ready with average_current, trip_active,
//   trip_event (trip newly set) and release_event (trip cleared).
//   Config request: cfg_valid/cfg_ready with cfg_index and cfg_data;
//   cfg_ready is always high. Index 0 slope, 1 offset, 2 trip level,
//   3 release margin. Write only while the block is idle.
// Sequence:
//   Each sample steps through MUL, OFS, SUB, ADD, DIV once per quotient
//   bit, SET, REL and OUT; the next is accepted only once OUT hands off the
//   result (SUM_W = 19 with the default window of 10). The restoring divider
//   makes one quotient bit per cycle on the shared add/subtract unit.
// Stall:
//   A finished result sits in the output register; the next sample is
//   accepted meanwhile, and the sequencer waits at its last step only if
//   that register is still full.
// Reset: arst_n clears the pointer, fill flag, running total, trip latch
//   and output valid, and restores the register reset values. The sample
//   ring is not cleared; an entry's value is used only after it was written.
// ----------------------------------------------------------------------------
module overcurrent_trip_monitor_unit #(
	parameter int WINDOW_LENGTH = otm_pkg::OTM_WINDOW_LENGTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [otm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [otm_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input samples
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [otm_pkg::ADC_W-1:0]       adc_sample,
	// results
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [otm_pkg::SAMPLE_W-1:0]         average_current,
	output logic                                 trip_active,
	output logic                                 trip_event,
	output logic                                 release_event
);
	import otm_pkg::*;

	localparam int PTR_W  = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
	localparam int CNT_W  = $clog2(WINDOW_LENGTH + 1);
	localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_LENGTH);
	localparam int ALU_W  = ((SUM_W > PROD_W) ? SUM_W : PROD_W) + 2;
	localparam int DCNT_W = $clog2(SUM_W);

	// configuration registers
	logic [SLOPE_W-1:0]         scale_slope_q;
	logic signed [OFFSET_W-1:0] scale_offset_q;
	logic [SAMPLE_W-1:0]        trip_level_q;
	logic [SAMPLE_W-1:0]        release_margin_q;

	// sequencer and datapath
	state_t                     state_q, state_d;
	logic [ADC_W-1:0]           raw_q;
	logic [PROD_W-1:0]          prod_q;
	logic [ADC_W+SLOPE_W-1:0]   prod_full;
	logic [SAMPLE_W-1:0]        amps_q;
	logic [SUM_W-1:0]           total_q;
	logic [SUM_W-1:0]           num_q;      // dividend, quotient shifts in
	logic [CNT_W-1:0]           rem_q;
	logic [CNT_W-1:0]           count_q;
	logic [DCNT_W-1:0]          div_cnt_q;
	logic signed [ALU_W-1:0]    rel_q;      // release threshold, may go negative
	logic [PTR_W-1:0]           wp_q;
	logic                       filled_q;
	logic                       latch_q;
	logic                       set_hit_q;
	logic                       tev_q;
	logic                       rev_q;
	logic [CNT_W:0]             trial;

	// output register
	logic                       out_valid_q;
	logic [SAMPLE_W-1:0]        avg_q;
	logic                       act_q;
	logic                       tev_out_q;
	logic                       rev_out_q;

	// shared unit
	alu_op_t                    alu_op;
	logic signed [ALU_W-1:0]    alu_a;
	logic signed [ALU_W-1:0]    alu_b;
	logic signed [ALU_W-1:0]    alu_y;
	logic                       alu_neg;

	// ring memory
	logic                       ram_we;
	logic                       ram_re;
	logic [SAMPLE_W-1:0]        ram_rdata;

	logic                       in_acc;
	logic                       out_load;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	assign ram_re    = in_acc;
	assign ram_we    = (state_q == ST_SUB);
	assign prod_full = raw_q * scale_slope_q;
	assign trial     = {rem_q, num_q[SUM_W-1]};

	assign out_valid       = out_valid_q;
	assign average_current = avg_q;
	assign trip_active     = act_q;
	assign trip_event      = tev_out_q;
	assign release_event   = rev_out_q;

	otm_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(WINDOW_LENGTH),
		.ADDR_W(PTR_W)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (amps_q),
		.re    (ram_re),
		.raddr (wp_q),
		.rdata (ram_rdata)
	);

	otm_alu #(
		.W(ALU_W)
	) u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.y   (alu_y),
		.neg (alu_neg)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_slope_q    <= SLOPE_RST;
			scale_offset_q   <= OFFSET_RST;
			trip_level_q     <= LEVEL_RST;
			release_margin_q <= MARGIN_RST;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SCALE_SLOPE:    scale_slope_q    <= cfg_data;
				CFG_SCALE_OFFSET:   scale_offset_q   <= cfg_data;
				CFG_TRIP_LEVEL:     trip_level_q     <= cfg_data[SAMPLE_W-1:0];
				CFG_RELEASE_MARGIN: release_margin_q <= cfg_data[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	// shared unit operand selection per step
	always_comb begin
		alu_op = ALU_SUB;
		alu_a  = '0;
		alu_b  = '0;
		case (state_q)
			ST_MUL: begin
				// release threshold = level - margin
				alu_a = {{(ALU_W-SAMPLE_W){1'b0}}, trip_level_q};
				alu_b = {{(ALU_W-SAMPLE_W){1'b0}}, release_margin_q};
			end
			ST_OFS: begin
				alu_op = ALU_ADD;
				alu_a  = {{(ALU_W-PROD_W){1'b0}}, prod_q};
				alu_b  = {{(ALU_W-OFFSET_W){scale_offset_q[OFFSET_W-1]}}, scale_offset_q};
			end
			ST_SUB: begin
				alu_a = {{(ALU_W-SUM_W){1'b0}}, total_q};
				alu_b = {{(ALU_W-SAMPLE_W){1'b0}}, ram_rdata};
			end
			ST_ADD: begin
				alu_op = ALU_ADD;
				alu_a  = {{(ALU_W-SUM_W){1'b0}}, total_q};
				alu_b  = {{(ALU_W-SAMPLE_W){1'b0}}, amps_q};
			end
			ST_DIV: begin
				alu_a = {{(ALU_W-CNT_W-1){1'b0}}, trial};
				alu_b = {{(ALU_W-CNT_W){1'b0}}, count_q};
			end
			ST_SET: begin
				// negative when mean > level
				alu_a = {{(ALU_W-SAMPLE_W){1'b0}}, trip_level_q};
				alu_b = {{(ALU_W-SAMPLE_W){1'b0}}, num_q[SAMPLE_W-1:0]};
			end
			ST_REL: begin
				// negative when mean < release threshold
				alu_a = {{(ALU_W-SAMPLE_W){1'b0}}, num_q[SAMPLE_W-1:0]};
				alu_b = rel_q;
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_acc) state_d = ST_MUL;
			ST_MUL:  state_d = ST_OFS;
			ST_OFS:  state_d = ST_SUB;
			ST_SUB:  state_d = ST_ADD;
			ST_ADD:  state_d = ST_DIV;
			ST_DIV:  if (div_cnt_q == '0) state_d = ST_SET;
			ST_SET:  state_d = ST_REL;
			ST_REL:  state_d = ST_OUT;
			ST_OUT:  if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			filled_q  <= 1'b0;
			total_q   <= '0;
			latch_q   <= 1'b0;
			div_cnt_q <= '0;
			count_q   <= '0;
		end else begin
			case (state_q)
				ST_SUB: begin
					if (filled_q) begin
						total_q <= alu_y[SUM_W-1:0];
					end
				end
				ST_ADD: begin
					total_q   <= alu_y[SUM_W-1:0];
					div_cnt_q <= DCNT_W'(SUM_W - 1);
					if (wp_q == PTR_W'(WINDOW_LENGTH - 1)) begin
						wp_q     <= '0;
						filled_q <= 1'b1;
						count_q  <= CNT_W'(WINDOW_LENGTH);
					end else begin
						wp_q    <= wp_q + 1'b1;
						count_q <= filled_q ? CNT_W'(WINDOW_LENGTH)
						                    : CNT_W'(wp_q) + 1'b1;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q - 1'b1;
				end
				ST_REL: begin
					if (!latch_q && set_hit_q) begin
						latch_q <= 1'b1;
					end else if (latch_q && alu_neg) begin
						latch_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			raw_q <= adc_sample;
		end
		case (state_q)
			ST_MUL: begin
				prod_q <= prod_full[ADC_W+SLOPE_W-1:FRAC_W];
				rel_q  <= alu_y;
			end
			ST_OFS: begin
				// clamp to [0, SAMPLE_MAX]
				if (alu_neg) begin
					amps_q <= '0;
				end else if (|alu_y[ALU_W-2:SAMPLE_W]) begin
					amps_q <= SAMPLE_MAX;
				end else begin
					amps_q <= alu_y[SAMPLE_W-1:0];
				end
			end
			ST_ADD: begin
				num_q <= alu_y[SUM_W-1:0];
				rem_q <= '0;
			end
			ST_DIV: begin
				// restoring division, one quotient bit per cycle
				if (alu_neg) begin
					rem_q <= trial[CNT_W-1:0];
				end else begin
					rem_q <= alu_y[CNT_W-1:0];
				end
				num_q <= {num_q[SUM_W-2:0], ~alu_neg};
			end
			ST_SET: begin
				set_hit_q <= alu_neg;
			end
			ST_REL: begin
				tev_q <= !latch_q && set_hit_q;
				rev_q <= latch_q && alu_neg;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			avg_q     <= num_q[SAMPLE_W-1:0];
			act_q     <= latch_q;
			tev_out_q <= tev_q;
			rev_out_q <= rev_q;
		end
	end

endmodule
`default_nettype wire

[sv/otm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// otm_checker - port-level checks for the overcurrent trip monitor
// Watches the top level's channels and result flags.
// ----------------------------------------------------------------------------
module otm_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            in_valid,
	input wire logic                            in_ready,
	input wire logic                            out_valid,
	input wire logic                            out_ready,
	input wire logic [otm_pkg::SAMPLE_W-1:0]    average_current,
	input wire logic                            trip_active,
	input wire logic                            trip_event,
	input wire logic                            release_event
);

	// one sample in flight: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready high right after an accepted request");

	a_events_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(trip_event && release_event))
		else $error("trip and release events in the same result");

	a_event_matches_latch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((!trip_event || trip_active) && (!release_event || !trip_active)))
		else $error("event flag disagrees with trip_active");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(average_current)
		&& $stable(trip_active)))
		else $error("stalled result changed");

endmodule

bind overcurrent_trip_monitor_unit otm_checker u_otm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.average_current (average_current),
	.trip_active     (trip_active),
	.trip_event      (trip_event),
	.release_event   (release_event)
);
`default_nettype wire

[tb/sv/overcurrent_trip_monitor_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overcurrent_trip_monitor_checker - result predictor and scoreboard
// Watches the config, sample and result requests of the trip monitor, keeps
// its own copy of the averaging ring and trip latch, and compares every
// result with the oldest prediction.
// ----------------------------------------------------------------------------
module overcurrent_trip_monitor_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	input  wire logic                            cfg_ready,
	input  wire logic [otm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [otm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            in_valid,
	input  wire logic                            in_ready,
	input  wire logic [otm_pkg::ADC_W-1:0]       adc_sample,
	input  wire logic                            out_valid,
	input  wire logic                            out_ready,
	input  wire logic [otm_pkg::SAMPLE_W-1:0]    average_current,
	input  wire logic                            trip_active,
	input  wire logic                            trip_event,
	input  wire logic                            release_event,
	output int                                   fail_count,
	output int                                   pending_count,
	output int                                   checked_count,
	output int                                   trip_count,
	output int                                   release_count
);
	import otm_pkg::*;

	localparam int RING_DEPTH = OTM_WINDOW_LENGTH;
	localparam int TOTAL_W    = 19;
	localparam int SHOWN_MAX  = 10;

	typedef struct packed {
		logic [SAMPLE_W-1:0] average;
		logic                active;
		logic                tripped;
		logic                released;
	} reading_t;

	// register copies
	logic [SLOPE_W-1:0]         slope;
	logic signed [OFFSET_W-1:0] offset;
	logic [SAMPLE_W-1:0]        level;
	logic [SAMPLE_W-1:0]        margin;

	// averaging state
	logic [SAMPLE_W-1:0] ring [RING_DEPTH];
	int unsigned         slot;
	logic                filled;
	logic [TOTAL_W-1:0]  total;
	logic                latched;

	reading_t expected_readings [$];

	function automatic logic [SAMPLE_W-1:0] to_amps(input logic [ADC_W-1:0] raw);
		logic [ADC_W+SLOPE_W-1:0] product;
		int                       amps;
		product = raw * slope;
		amps = int'(product >> FRAC_W) + int'(offset);
		if (amps < 0)
			amps = 0;
		else if (amps > int'(SAMPLE_MAX))
			amps = int'(SAMPLE_MAX);
		return amps[SAMPLE_W-1:0];
	endfunction

	// advances the ring and latch by one sample
	function automatic reading_t predict_reading(input logic [ADC_W-1:0] raw);
		logic [SAMPLE_W-1:0] amps;
		int unsigned         held;
		int unsigned         mean;
		int                  release_at;
		reading_t            r;
		amps = to_amps(raw);
		if (filled)
			total = total - ring[slot];
		ring[slot] = amps;
		total = total + amps;
		slot = slot + 1;
		if (slot >= RING_DEPTH) begin
			slot = 0;
			filled = 1'b1;
		end
		held = filled ? RING_DEPTH : slot;
		mean = int'(total) / held;
		if (mean > SAMPLE_MAX)
			mean = SAMPLE_MAX;
		release_at = int'(level) - int'(margin);
		r = '0;
		if (!latched && mean > level) begin
			latched = 1'b1;
			r.tripped = 1'b1;
		end else if (latched && int'(mean) < release_at) begin
			latched = 1'b0;
			r.released = 1'b1;
		end
		r.average = mean[SAMPLE_W-1:0];
		r.active = latched;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : scoreboard
		reading_t got;
		reading_t want;
		if (!arst_n) begin
			slope = SLOPE_RST;
			offset = OFFSET_RST;
			level = LEVEL_RST;
			margin = MARGIN_RST;
			slot = 0;
			filled = 1'b0;
			total = '0;
			latched = 1'b0;
			expected_readings.delete();
			fail_count = 0;
			checked_count = 0;
			trip_count = 0;
			release_count = 0;
			pending_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_SCALE_SLOPE:    slope = cfg_data;
					CFG_SCALE_OFFSET:   offset = cfg_data;
					CFG_TRIP_LEVEL:     level = cfg_data[SAMPLE_W-1:0];
					CFG_RELEASE_MARGIN: margin = cfg_data[SAMPLE_W-1:0];
					default: ;
				endcase
			end
			// drain before fill: a result never pairs with a sample of the same edge
			if (out_valid && out_ready) begin
				got.average = average_current;
				got.active = trip_active;
				got.tripped = trip_event;
				got.released = release_event;
				if (expected_readings.size() == 0) begin
					fail_count++;
					if (fail_count <= SHOWN_MAX)
						$display("%0t: result avg=%0d active=%b trip=%b release=%b with no sample outstanding",
							$realtime, got.average, got.active, got.tripped, got.released);
				end else begin
					want = expected_readings.pop_front();
					checked_count++;
					if (want.tripped)
						trip_count++;
					if (want.released)
						release_count++;
					if (got.average !== want.average || got.active !== want.active ||
							got.tripped !== want.tripped || got.released !== want.released) begin
						fail_count++;
						if (fail_count <= SHOWN_MAX)
							$display("%0t: result %0d expected avg=%0d active=%b trip=%b release=%b, got avg=%0d active=%b trip=%b release=%b",
								$realtime, checked_count, want.average, want.active, want.tripped,
								want.released, got.average, got.active, got.tripped, got.released);
					end
				end
			end
			if (in_valid && in_ready)
				expected_readings.push_back(predict_reading(adc_sample));
			pending_count <= expected_readings.size();
		end
	end

endmodule

[tb/sv/overcurrent_trip_monitor_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overcurrent_trip_monitor_unit_tb - testbench top for the trip monitor
// Drives ADC samples and register writes into the block, pulls results with
// random back-pressure, and lets the checker predict and compare each one.
// ----------------------------------------------------------------------------
// Flow:
//   - directed samples: exact threshold hits, clamp and saturate, masked
//     register widths, a release margin larger than the trip level, ring wrap
//   - random samples in bursts that swing the mean across the trip and
//     release thresholds, under three flow-control mixes and many settings
//   - one long result hold-off with the sender still pushing, so the block
//     backs up into its sample input
// Registers change only with nothing in flight (sender drains first).
// ----------------------------------------------------------------------------
module overcurrent_trip_monitor_unit_tb;
	import otm_pkg::*;

	localparam int SEG_ITEMS  = 110;     // samples per random register setting
	localparam int SEG_COUNT  = 6;       // settings per flow-control mix
	localparam int LONG_HOLD  = 400;     // length of the long result hold-off
	localparam int TAIL_WAIT  = 64;      // wait after the final drain
	localparam int WAIT_LIMIT = 4000000; // ns

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [ADC_W-1:0]      adc_sample;
	logic                  out_valid;
	logic                  out_ready;
	logic [SAMPLE_W-1:0]   average_current;
	logic                  trip_active;
	logic                  trip_event;
	logic                  release_event;

	// flow control knobs; receiver side read only by the sink process
	int   sender_idle_pct;
	int   receiver_idle_pct;
	logic hold_token;          // toggled to ask the sink for a long hold-off

	int fail_count;
	int pending_count;
	int checked_count;
	int trip_count;
	int release_count;
	int samples_sent;
	int setting_count;

	always #2 clk = ~clk;

	overcurrent_trip_monitor_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.adc_sample      (adc_sample),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.average_current (average_current),
		.trip_active     (trip_active),
		.trip_event      (trip_event),
		.release_event   (release_event)
	);

	overcurrent_trip_monitor_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.adc_sample      (adc_sample),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.average_current (average_current),
		.trip_active     (trip_active),
		.trip_event      (trip_event),
		.release_event   (release_event),
		.fail_count      (fail_count),
		.pending_count   (pending_count),
		.checked_count   (checked_count),
		.trip_count      (trip_count),
		.release_count   (release_count)
	);

	// Hard stop in case a request never completes.
	initial begin : watchdog
		#WAIT_LIMIT;
		$display("timeout with %0d results outstanding", pending_count);
		$display("CHECKS FAILED");
		$finish;
	end

	// Result sink: random ready, or held low after each toggle of hold_token until
	// the hold-off counter runs out. Counting lives here so the sender keeps running.
	initial begin : result_sink
		int   hold_left;
		logic token_seen;
		hold_left = 0;
		token_seen = 1'b0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_token != token_seen) begin
				token_seen = hold_token;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= receiver_idle_pct);
			end
		end
	end

	// One sample request. Valid is left high after acceptance so that a
	// back-to-back sample never lowers and raises it in the same step; a gap
	// or a drain lowers it first.
	task automatic offer_sample(input logic [ADC_W-1:0] value);
		if ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < sender_idle_pct);
		end
		in_valid <= 1'b1;
		adc_sample <= value;
		do
			@(posedge clk);
		while (!in_ready);
		samples_sent++;
	endtask

	// Stop offering and wait until every predicted result came back.
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_count != 0);
	endtask

	task automatic write_reg(input cfg_idx_t index, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
	endtask

	// Full register set, written only once the block is quiet.
	task automatic write_settings(input logic [CFG_DATA_W-1:0] slope_d,
			input logic [CFG_DATA_W-1:0] offset_d, input logic [CFG_DATA_W-1:0] level_d,
			input logic [CFG_DATA_W-1:0] margin_d);
		drain_results();
		write_reg(CFG_SCALE_SLOPE, slope_d);
		write_reg(CFG_SCALE_OFFSET, offset_d);
		write_reg(CFG_TRIP_LEVEL, level_d);
		write_reg(CFG_RELEASE_MARGIN, margin_d);
		cfg_valid <= 1'b0;
		setting_count++;
	endtask

	initial begin : stimulus
		logic [CFG_DATA_W-1:0] slope_d;
		logic [CFG_DATA_W-1:0] offset_d;
		logic [CFG_DATA_W-1:0] level_d;
		logic [CFG_DATA_W-1:0] margin_d;
		int slope_v;
		int offset_v;
		int level_v;
		int margin_v;
		int center;
		int span;
		int swing;
		int burst;
		int v;
		int n;
		int kind;
		int tmp;
		bit up;

		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_SCALE_SLOPE;
		cfg_data <= '0;
		in_valid <= 1'b0;
		adc_sample <= '0;
		hold_token <= 1'b0;
		receiver_idle_pct <= 82;
		sender_idle_pct = 19;
		samples_sent = 0;
		setting_count = 0;
		up = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part ----
		// Unity scale (amps == raw). Fresh ring: mean 1000 equals the level
		// (no trip), then 1001 trips, 900 equals the release point (holds),
		// 675 releases.
		write_settings(16'd1024, 16'd0, 16'd1000, 16'd100);
		offer_sample(12'd1000);
		offer_sample(12'd1002);
		offer_sample(12'd698);
		offer_sample(12'd0);
		// Full slope plus full positive offset saturates every sample; a mean
		// of 32767 sits exactly on the top trip level.
		write_settings(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h0000);
		offer_sample(12'hFFF);
		offer_sample(12'h000);
		// Margin above the level: the trip sets and never lets go, even after
		// the ring wraps and the mean falls to zero.
		write_settings(16'd1024, 16'd0, 16'd100, 16'd200);
		offer_sample(12'd500);
		repeat (11) offer_sample(12'd0);
		// Zero slope and most negative offset clamp to zero; bit 15 of the
		// level write is dropped, so the level becomes zero.
		write_settings(16'd0, 16'h8000, 16'h8000, 16'h7FFF);
		offer_sample(12'hFFF);
		// Back to power-on values.
		write_settings(SLOPE_RST, OFFSET_RST, {1'b0, LEVEL_RST}, {1'b0, MARGIN_RST});
		offer_sample(12'd0);
		offer_sample(12'hFFF);
		offer_sample(12'd2048);

		// ---- random part ----
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin sender_idle_pct = 19; receiver_idle_pct <= 82; end
				1: begin sender_idle_pct = 82; receiver_idle_pct <= 19; end
				default: begin sender_idle_pct = 0; receiver_idle_pct <= 0; end
			endcase
			for (int seg = 0; seg < SEG_COUNT; seg++) begin
				kind = $urandom_range(9);
				if (kind == 0) begin
					// anything goes, including bit 15 on level and margin
					slope_d = 16'($urandom);
					offset_d = 16'($urandom);
					level_d = 16'($urandom);
					margin_d = 16'($urandom);
				end else if (kind == 1) begin
					// corners of every register
					slope_d = $urandom_range(1) ? 16'hFFFF : 16'h0000;
					offset_d = $urandom_range(1) ? 16'h7FFF : 16'h8000;
					level_d = $urandom_range(1) ? 16'h7FFF : 16'h0000;
					margin_d = $urandom_range(1) ? 16'h7FFF : 16'h0000;
				end else if (kind == 2) begin
					slope_d = SLOPE_RST;
					offset_d = OFFSET_RST;
					level_d = {1'b0, LEVEL_RST};
					margin_d = {1'b0, MARGIN_RST};
				end else begin
					// reachable level with a modest margin, now and then one
					// larger than the level itself
					slope_d = 16'($urandom_range(2048, 16384));
					tmp = int'($urandom_range(8191)) - 4096;
					offset_d = tmp[15:0];
					tmp = $urandom_range(1024, 30000);
					level_d = tmp[15:0];
					if ($urandom_range(9) == 0)
						tmp = tmp + int'($urandom_range(1, 2000));
					else
						tmp = $urandom_range(tmp / 4);
					if (tmp > 32767)
						tmp = 32767;
					margin_d = tmp[15:0];
				end
				write_settings(slope_d, offset_d, level_d, margin_d);

				// Long result hold-off while samples keep coming.
				if (mode == 2 && seg == 0)
					hold_token <= ~hold_token;

				// Raw count that lands on the trip level, and a swing that
				// reaches past the release margin.
				slope_v = int'(slope_d);
				offset_v = int'($signed(offset_d));
				level_v = int'(level_d[SAMPLE_W-1:0]);
				margin_v = int'(margin_d[SAMPLE_W-1:0]);
				if (slope_v == 0) begin
					center = $urandom_range(4095);
					span = 512;
				end else begin
					center = ((level_v - offset_v) * 1024) / slope_v;
					span = ((margin_v + 512) * 1024) / slope_v;
				end
				if (center < 0)
					center = 0;
				if (center > 4095)
					center = 4095;
				if (span > 4095)
					span = 4095;

				// Bursts alternate above and below the level, with a sprinkle of
				// full-range noise samples.
				n = 0;
				while (n < SEG_ITEMS) begin
					burst = $urandom_range(3, 20);
					up = ~up;
					swing = $urandom_range(span / 2, span + 64);
					while (burst > 0 && n < SEG_ITEMS) begin
						if ($urandom_range(9) == 0)
							v = $urandom_range(4095);
						else
							v = center + (up ? swing : -swing) + int'($urandom_range(64)) - 32;
						if (v < 0)
							v = 0;
						if (v > 4095)
							v = 4095;
						offer_sample(v[ADC_W-1:0]);
						burst--;
						n++;
					end
				end
			end
		end

		// ---- wrap-up ----
		drain_results();
		repeat (TAIL_WAIT) @(posedge clk);
		$display("Sent %0d samples, %0d results compared, across %0d register settings",
			samples_sent, checked_count, setting_count);
		$display("and three back-pressure mixes; %0d trips and %0d releases predicted",
			trip_count, release_count);
		if (fail_count == 0 && pending_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[files.f]
sv/otm_pkg.sv
sv/otm_ram.sv
sv/otm_alu.sv
sv/overcurrent_trip_monitor_unit.sv
sv/otm_checker.sv
tb/sv/overcurrent_trip_monitor_checker.sv
tb/sv/overcurrent_trip_monitor_unit_tb.sv
